// ----- src/wcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_pkg
// Shared widths, constants and types of the windowed chain distance block.
// ----------------------------------------------------------------------------
package wcd_pkg;

  localparam int COORD_W     = 25;
  localparam int CHAIN_W     = 8;
  localparam int IDX_W       = 16;
  localparam int K_W         = 6;
  localparam int FILL_W      = 7;
  localparam int DIST_W      = 25;
  localparam int ABS_W       = 25;
  localparam int SQ_W        = 2 * ABS_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int MAX_RESULTS = 32;
  localparam int MAX_WINDOW  = 32;

  localparam logic [K_W-1:0]   NDIST_RESET = K_W'(20);
  localparam logic [IDX_W-1:0] IDX_MAX     = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [IDX_W-1:0]          idx;
    logic [K_W-1:0]            n;
    logic [K_W-1:0]            fill;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0] newer_index;
    logic [K_W-1:0]   offset;
    logic             present;
    logic             last;
  } tag_t;

endpackage

// ----- src/wcd_atom_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_atom_if
// Input channel: one atom position with chain and structure marks per beat.
// ----------------------------------------------------------------------------
interface wcd_atom_if import wcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic [CHAIN_W-1:0]        chain_id;
  logic                      new_structure;

  modport source (output valid, x_coord, y_coord, z_coord, chain_id, new_structure,
                  input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, chain_id, new_structure,
                  output ready);
endinterface

// ----- src/wcd_dist_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_dist_if
// Output channel: one neighbor distance per beat.
// ----------------------------------------------------------------------------
interface wcd_dist_if import wcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  newer_index;
  logic [K_W-1:0]    offset;
  logic [DIST_W-1:0] distance;
  logic              present;
  logic              last;

  modport source (output valid, newer_index, offset, distance, present, last,
                  input ready);
  modport sink   (input valid, newer_index, offset, distance, present, last,
                  output ready);
endinterface

// ----- src/wcd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(Depth>1?$clog2(Depth):1)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [(Depth>1?$clog2(Depth):1)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- src/wcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_front
// Accepts atoms, tracks structure and chain bookkeeping, builds one job each.
// ----------------------------------------------------------------------------
module wcd_front import wcd_pkg::*; #(
  parameter int MaxWindow = MAX_WINDOW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  wcd_atom_if.sink       atom_i,
  input  logic           cfg_we_i,
  input  logic [K_W-1:0] cfg_wdata_i,
  output job_t           job_o,
  output logic           job_valid_o,
  input  logic           job_ready_i
);
  localparam int NLim = (MaxWindow < MAX_RESULTS) ? MaxWindow : MAX_RESULTS;

  logic [K_W-1:0]     ndist_q;
  logic [IDX_W-1:0]   count_q, count_d;
  logic [FILL_W-1:0]  fill_q, fill_d, fill_base;
  logic [CHAIN_W-1:0] chain_q;
  logic               restart, accept;
  logic [IDX_W-1:0]   idx;

  assign atom_i.ready = job_ready_i;
  assign job_valid_o  = atom_i.valid;
  assign accept       = atom_i.valid && job_ready_i;

  always_comb begin
    restart   = atom_i.new_structure || (atom_i.chain_id != chain_q);
    idx       = atom_i.new_structure ? '0 : count_q;
    fill_base = restart ? '0 : fill_q;
    fill_d    = (fill_base < FILL_W'(MaxWindow)) ? fill_base + FILL_W'(1) : fill_base;
    count_d   = (idx != IDX_MAX) ? idx + IDX_W'(1) : idx;

    job_o.x   = atom_i.x_coord;
    job_o.y   = atom_i.y_coord;
    job_o.z   = atom_i.z_coord;
    job_o.idx = idx;
    job_o.n   = (ndist_q > K_W'(NLim)) ? K_W'(NLim) : ndist_q;
    job_o.fill = (fill_base > FILL_W'(MAX_RESULTS)) ? K_W'(MAX_RESULTS)
                                                    : fill_base[K_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndist_q <= NDIST_RESET;
      count_q <= '0;
      fill_q  <= '0;
      chain_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ndist_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
        fill_q  <= fill_d;
        chain_q <= atom_i.chain_id;
      end
    end
  end
endmodule

// ----- src/wcd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module wcd_fifo import wcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);
  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- src/wcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_back
// Walks the offsets of one job, reads the position ring, and runs squared
// distances through a one-bit-per-stage square root pipeline.
// ----------------------------------------------------------------------------
module wcd_back import wcd_pkg::*; #(
  parameter int MaxWindow = MAX_WINDOW
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  wcd_dist_if.source dist_o
);
  localparam int AW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;

  typedef enum logic [1:0] {IDLE, ISSUE, STORE} state_e;

  state_e         state_q;
  job_t           job_q;
  logic [K_W-1:0] k_q;
  logic [AW-1:0]  head_q;

  logic           en, issue;
  logic [AW:0]    slot_sum, slot;
  logic [3*COORD_W-1:0] rdata;

  // issue stage
  logic                      p1_valid_q;
  tag_t                      p1_tag_q;
  logic signed [COORD_W-1:0] p1_x_q, p1_y_q, p1_z_q;
  // squares stage
  logic                      p2_valid_q;
  tag_t                      p2_tag_q;
  logic [SQ_W-1:0]           p2_sx_q, p2_sy_q, p2_sz_q;
  logic [ABS_W-1:0]          ax, ay, az;

  // root pipeline, stage 0 holds the sum
  logic              s_valid_q [ROOT_W+1];
  tag_t              s_tag_q   [ROOT_W+1];
  logic [SUM_W-1:0]  s_rad_q   [ROOT_W+1];
  logic [REM_W-1:0]  s_rem_q   [ROOT_W+1];
  logic [ROOT_W-1:0] s_root_q  [ROOT_W+1];
  logic [SUM_W-1:0]  s_rad_d   [ROOT_W];
  logic [REM_W-1:0]  s_rem_d   [ROOT_W];
  logic [ROOT_W-1:0] s_root_d  [ROOT_W];

  logic              out_valid_q;
  tag_t              out_tag_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [ROOT_W-1:0] root_f;

  function automatic logic [ABS_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? ABS_W'(-d) : ABS_W'(d);
  endfunction

  assign en          = !out_valid_q || dist_o.ready;
  assign issue       = (state_q == ISSUE) && en;
  assign job_ready_o = (state_q == IDLE);

  always_comb begin
    slot_sum = {1'b0, head_q} + (AW+1)'(MaxWindow) - (AW+1)'(k_q);
    slot     = (slot_sum >= (AW+1)'(MaxWindow)) ? slot_sum - (AW+1)'(MaxWindow) : slot_sum;
  end

  wcd_ram #(.Width(3*COORD_W), .Depth(MaxWindow)) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == STORE),
    .waddr_i (head_q),
    .wdata_i ({job_q.x, job_q.y, job_q.z}),
    .re_i    (issue),
    .raddr_i (slot[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      k_q     <= '0;
      head_q  <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (job_valid_i) begin
            k_q     <= K_W'(1);
            state_q <= (job_i.n == '0) ? STORE : ISSUE;
          end
        end
        ISSUE: begin
          if (en) begin
            if (k_q == job_q.n) begin
              state_q <= STORE;
            end else begin
              k_q <= k_q + K_W'(1);
            end
          end
        end
        STORE: begin
          // the atom joins the ring only after all its reads went out
          head_q  <= (head_q == AW'(MaxWindow - 1)) ? '0 : head_q + AW'(1);
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == IDLE && job_valid_i) begin
      job_q <= job_i;
    end
  end

  always_comb begin
    ax = abs_diff(p1_x_q, rdata[3*COORD_W-1 -: COORD_W]);
    ay = abs_diff(p1_y_q, rdata[2*COORD_W-1 -: COORD_W]);
    az = abs_diff(p1_z_q, rdata[COORD_W-1:0]);
  end

  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      logic [REM_W-1:0] r, t;
      r = {s_rem_q[j][REM_W-3:0], s_rad_q[j][SUM_W-1 -: 2]};
      t = REM_W'({s_root_q[j], 2'b01});
      s_rad_d[j] = {s_rad_q[j][SUM_W-3:0], 2'b00};
      if (r >= t) begin
        s_rem_d[j]  = r - t;
        s_root_d[j] = {s_root_q[j][ROOT_W-2:0], 1'b1};
      end else begin
        s_rem_d[j]  = r;
        s_root_d[j] = {s_root_q[j][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j <= ROOT_W; j++) begin
        s_valid_q[j] <= 1'b0;
      end
    end else if (en) begin
      p1_valid_q   <= issue;
      p2_valid_q   <= p1_valid_q;
      s_valid_q[0] <= p2_valid_q;
      for (int j = 0; j < ROOT_W; j++) begin
        s_valid_q[j+1] <= s_valid_q[j];
      end
      out_valid_q <= s_valid_q[ROOT_W];
    end
  end

  assign root_f = s_root_q[ROOT_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_tag_q.newer_index <= job_q.idx;
      p1_tag_q.offset      <= k_q;
      p1_tag_q.present     <= (k_q <= job_q.fill);
      p1_tag_q.last        <= (k_q == job_q.n);
      p1_x_q               <= job_q.x;
      p1_y_q               <= job_q.y;
      p1_z_q               <= job_q.z;

      p2_tag_q <= p1_tag_q;
      p2_sx_q  <= ax * ax;
      p2_sy_q  <= ay * ay;
      p2_sz_q  <= az * az;

      s_tag_q[0]  <= p2_tag_q;
      s_rad_q[0]  <= SUM_W'(p2_sx_q) + SUM_W'(p2_sy_q) + SUM_W'(p2_sz_q);
      s_rem_q[0]  <= '0;
      s_root_q[0] <= '0;
      for (int j = 0; j < ROOT_W; j++) begin
        s_tag_q[j+1]  <= s_tag_q[j];
        s_rad_q[j+1]  <= s_rad_d[j];
        s_rem_q[j+1]  <= s_rem_d[j];
        s_root_q[j+1] <= s_root_d[j];
      end

      out_tag_q <= s_tag_q[ROOT_W];
      // drop the distance of absent entries, clip the rest to the field
      if (!s_tag_q[ROOT_W].present) begin
        out_dist_q <= '0;
      end else if (root_f[ROOT_W-1:DIST_W] != '0) begin
        out_dist_q <= '1;
      end else begin
        out_dist_q <= root_f[DIST_W-1:0];
      end
    end
  end

  assign dist_o.valid       = out_valid_q;
  assign dist_o.newer_index = out_tag_q.newer_index;
  assign dist_o.offset      = out_tag_q.offset;
  assign dist_o.distance    = out_dist_q;
  assign dist_o.present     = out_tag_q.present;
  assign dist_o.last        = out_tag_q.last;
endmodule

// ----- src/windowed_chain_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_chain_distance
// For each atom, distances to the previous ndist atoms of the same chain.
// ----------------------------------------------------------------------------
// Each accepted atom yields ndist beats (clamped to the window and to 32), one
// per offset, offset 1 first, last set on the final one. The back end issues
// one offset per clock out of the position ring unless the output stalls; the
// ring has one read port, so an atom occupies the back end for a job load, its
// ndist ring reads and a ring write; a two-entry job queue lets the input keep
// taking atoms meanwhile. A beat passes the issue, squares and sum registers,
// the square root stages (one bit per stage) and the output register. Output
// back-pressure stalls the whole pipeline. No clearing is needed after reset.
module windowed_chain_distance import wcd_pkg::*; #(
  parameter int MaxWindow = MAX_WINDOW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  wcd_atom_if.sink       atom_i,
  wcd_dist_if.source     dist_o,
  input  logic           cfg_we_i,
  input  logic [K_W-1:0] cfg_wdata_i
);
  job_t front_job, back_job;
  logic front_valid, front_ready, back_valid, back_ready;

  wcd_front #(.MaxWindow(MaxWindow)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .atom_i      (atom_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  wcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  wcd_back #(.MaxWindow(MaxWindow)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .dist_o      (dist_o)
  );
endmodule

// ----- src/wcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcd_checker
// Port-level checks of the distance output, bound to the top level.
// ----------------------------------------------------------------------------
module wcd_checker import wcd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [K_W-1:0]    cfg_wdata_i,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  out_index,
  input logic [K_W-1:0]    out_offset,
  input logic [DIST_W-1:0] out_distance,
  input logic              out_present,
  input logic              out_last
);
  logic [K_W-1:0] ndist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndist_q <= NDIST_RESET;
    end else if (cfg_we_i) begin
      ndist_q <= cfg_wdata_i;
    end
  end

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_present |-> out_distance == '0)
    else $error("absent beat carries a nonzero distance");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_offset != '0 && out_offset <= ndist_q
                  && out_offset <= K_W'(MAX_RESULTS))
    else $error("offset outside 1..ndist");

  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last ##1 out_valid |-> out_offset != K_W'(1))
    else $error("offset restarted before last beat");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_index)
                                && $stable(out_offset) && $stable(out_distance))
    else $error("stalled beat changed");
endmodule

bind windowed_chain_distance wcd_checker u_wcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_wdata_i  (cfg_wdata_i),
  .out_valid    (dist_o.valid),
  .out_ready    (dist_o.ready),
  .out_index    (dist_o.newer_index),
  .out_offset   (dist_o.offset),
  .out_distance (dist_o.distance),
  .out_present  (dist_o.present),
  .out_last     (dist_o.last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives atom beats through windowed_chain_distance and compares every
// distance beat with a behavioral prediction. A directed table of atoms comes
// first, then random chains and structures, with several ndist settings.
// ----------------------------------------------------------------------------
module testbench;
  import wcd_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CHAIN_W-1:0]        chain;
    logic                      fresh;
    // -1 means no typed-in value for the first beat's distance
    longint                    dist0;
  } atom_row_t;

  typedef struct {
    logic [IDX_W-1:0]  newer_index;
    logic [K_W-1:0]    offset;
    logic [DIST_W-1:0] distance;
    logic              present;
    logic              last;
  } dist_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [K_W-1:0] cfg_wdata_i = '0;
  int unsigned fail_count = 0;

  wcd_atom_if atom_bus ();
  wcd_dist_if dist_bus ();

  windowed_chain_distance uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .atom_i      (atom_bus.sink),
    .dist_o      (dist_bus.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [K_W-1:0]    ndist_q;
  longint            ring_x [MAX_WINDOW];
  longint            ring_y [MAX_WINDOW];
  longint            ring_z [MAX_WINDOW];
  int unsigned       head_q, fill_q, chain_q, count_q;
  dist_beat_t        pending_beats[$];

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void predict_distances(atom_row_t a);
    int unsigned n, k, slot;
    longint dx, dy, dz;
    longint unsigned s, d;
    dist_beat_t b;
    n = (ndist_q > MAX_WINDOW) ? MAX_WINDOW : ndist_q;
    if (a.fresh) begin
      count_q = 0;
      fill_q = 0;
      chain_q = a.chain;
    end
    if (a.chain != chain_q) begin
      fill_q = 0;
      chain_q = a.chain;
    end
    for (k = 1; k <= n; k++) begin
      d = 0;
      b.present = 1'b0;
      if (k <= fill_q) begin
        slot = (head_q + MAX_WINDOW - k) % MAX_WINDOW;
        dx = longint'(a.x) - ring_x[slot];
        dy = longint'(a.y) - ring_y[slot];
        dz = longint'(a.z) - ring_z[slot];
        s = dx * dx + dy * dy + dz * dz;
        d = floor_sqrt(s);
        if (d > 64'h1FFFFFF) d = 64'h1FFFFFF;
        b.present = 1'b1;
      end
      b.newer_index = count_q[IDX_W-1:0];
      b.offset = K_W'(k);
      b.distance = d[DIST_W-1:0];
      b.last = (k == n);
      pending_beats.push_back(b);
    end
    ring_x[head_q] = a.x;
    ring_y[head_q] = a.y;
    ring_z[head_q] = a.z;
    head_q = (head_q + 1) % MAX_WINDOW;
    if (fill_q < MAX_WINDOW) fill_q++;
    if (count_q < 16'hFFFF) count_q++;
  endfunction

  // typed-in value for the first beat of the next atom, if any
  longint typed_dist0[$];

  // receiver: stall pattern of its own, check at the edge
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    dist_beat_t e;
    longint t;
    if (rst_ni && dist_bus.valid && dist_bus.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat idx=%0d off=%0d", $time,
                 dist_bus.newer_index, dist_bus.offset);
        fail_count++;
      end else begin
        e = pending_beats.pop_front();
        if (e.offset == 1 && typed_dist0.size() > 0) begin
          t = typed_dist0.pop_front();
          if (t >= 0 && longint'(e.distance) != t) begin
            $display("%0t: table distance expected %0d actual predictor %0d", $time,
                     t, e.distance);
            fail_count++;
          end
        end
        if (dist_bus.newer_index !== e.newer_index || dist_bus.offset !== e.offset ||
            dist_bus.distance !== e.distance || dist_bus.present !== e.present ||
            dist_bus.last !== e.last) begin
          $display("%0t: expected idx=%0d off=%0d dist=%0d pres=%0b last=%0b", $time,
                   e.newer_index, e.offset, e.distance, e.present, e.last);
          $display("%0t:   actual idx=%0d off=%0d dist=%0d pres=%0b last=%0b", $time,
                   dist_bus.newer_index, dist_bus.offset, dist_bus.distance,
                   dist_bus.present, dist_bus.last);
          fail_count++;
        end
      end
    end
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:8] == 2'd3) dist_bus.ready <= 1'b1;
    else dist_bus.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 13 != 5);
  end

  initial dist_bus.ready = 1'b0;

  int unsigned burst_left = 0;

  task automatic send_atom(atom_row_t a);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        atom_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    atom_bus.valid <= 1'b1;
    atom_bus.x_coord <= a.x;
    atom_bus.y_coord <= a.y;
    atom_bus.z_coord <= a.z;
    atom_bus.chain_id <= a.chain;
    atom_bus.new_structure <= a.fresh;
    @(posedge clk_i);
    while (!atom_bus.ready) @(posedge clk_i);
    if ((ndist_q > MAX_WINDOW ? MAX_WINDOW : ndist_q) != 0) typed_dist0.push_back(a.dist0);
    predict_distances(a);
  endtask

  task automatic drain_and_idle();
    atom_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_ndist(logic [K_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ndist_q = v;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return -COORD_W'(999999);
      1: return COORD_W'(9999999);
      2: return COORD_W'($urandom_range(0, 2000));
      default: return COORD_W'(longint'($urandom_range(0, 10999998)) - 999999);
    endcase
  endfunction

  task automatic random_phase(int unsigned items);
    atom_row_t a;
    int unsigned i;
    logic [CHAIN_W-1:0] ch;
    ch = 8'h41;
    for (i = 0; i < items; i++) begin
      if ($urandom_range(0, 39) == 0) ch = CHAIN_W'($urandom);
      else if ($urandom_range(0, 19) == 0) ch = ch + 8'd1;
      a.x = rand_coord();
      a.y = rand_coord();
      a.z = rand_coord();
      // full-range raw bits now and then so every input bit toggles
      if ($urandom_range(0, 15) == 0) a.x = COORD_W'($urandom);
      a.chain = ch;
      a.fresh = ($urandom_range(0, 49) == 0);
      a.dist0 = -1;
      send_atom(a);
    end
  endtask

  atom_row_t directed_rows[$];

  initial begin
    atom_row_t r;
    ndist_q = NDIST_RESET;
    head_q = 0; fill_q = 0; chain_q = 0; count_q = 0;
    atom_bus.valid = 1'b0;
    atom_bus.x_coord = '0;
    atom_bus.y_coord = '0;
    atom_bus.z_coord = '0;
    atom_bus.chain_id = '0;
    atom_bus.new_structure = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chain 0 after reset: first atom already has a chain, offset 1 absent
    directed_rows = '{
      '{25'sd0, 25'sd0, 25'sd0, 8'd0, 1'b0, 0},
      '{25'sd3000, 25'sd4000, 25'sd0, 8'd0, 1'b0, 5000},
      '{-25'sd999999, -25'sd999999, -25'sd999999, 8'd0, 1'b0, -1},
      '{25'sd9999999, 25'sd9999999, 25'sd9999999, 8'd0, 1'b0, 19052555},
      '{25'sd9999999, 25'sd9999999, 25'sd9999999, 8'd0, 1'b0, 0},
      '{25'sd1, 25'sd1, 25'sd1, 8'd66, 1'b0, 0},
      '{25'sd1, 25'sd1, 25'sd2, 8'd66, 1'b0, 1},
      '{25'sd5, 25'sd5, 25'sd5, 8'd255, 1'b1, 0},
      '{25'sd5, 25'sd5, 25'sd5, 8'd255, 1'b0, 0},
      '{25'sh1000000, 25'sh1000000, 25'sh1000000, 8'd255, 1'b0, -1},
      '{25'sd16777215, 25'sd16777215, 25'sd16777215, 8'd255, 1'b0, 33554431},
      '{25'sd7, 25'sd0, 25'sd0, 8'd255, 1'b1, 0}
    };
    foreach (directed_rows[i]) send_atom(directed_rows[i]);
    drain_and_idle();

    write_ndist(6'd1);
    random_phase(20);
    drain_and_idle();
    write_ndist(6'd0);
    r = '{25'sd100, 25'sd100, 25'sd100, 8'd255, 1'b0, -1};
    send_atom(r);
    send_atom(r);
    drain_and_idle();
    write_ndist(6'd63);
    random_phase(40);
    drain_and_idle();
    write_ndist(6'd32);
    random_phase(30);
    drain_and_idle();
    write_ndist(6'd5);
    random_phase(40);
    drain_and_idle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
